// ----- hw/rtl/float_sqrt_table_interp_unit_defines.svh -----
// Assertion macros shared by the square root unit.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef FLOAT_SQRT_TABLE_INTERP_UNIT_DEFINES_SVH
`define FLOAT_SQRT_TABLE_INTERP_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define FSTI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define FSTI_ASSERT_RESET(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FSTI_ASSERT(name, prop, msg)
`define FSTI_ASSERT_RESET(name, prop, msg)
`endif

`endif

// ----- hw/rtl/fsti_pkg.sv -----
// Shared constants, types and table-building functions of the square root unit.
// Depends on nothing.
`timescale 1ns / 1ps

package fsti_pkg;

  localparam int TABLE_ENTRIES      = 193;
  localparam int ENTRY_FRAC_BITS_DEF = 23;
  localparam int IDX_W              = $clog2(TABLE_ENTRIES);
  localparam int LOW_BITS           = 17;
  localparam int FRAC_W             = 23;
  localparam int EXP_W              = 8;
  localparam int WORD_W             = 32;
  localparam logic [EXP_W-1:0] EXP_SPECIAL = 8'hFF;
  localparam logic [EXP_W-1:0] EXP_REBIAS  = 8'd63;

  // Decoded word as it travels down the pipeline.
  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic                pass;
    logic                ovf;
    logic [EXP_W-1:0]    nexp;
    logic [IDX_W-1:0]    idx;
    logic [LOW_BITS-1:0] f;
  } dec_t;

  // Integer square root by the digit-pair method, used only at elaboration.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bit_w;
    integer k;
    v = v_in;
    r = '0;
    bit_w = 64'h1 << 62;
    for (k = 0; k < 32; k++) begin
      if (v >= r + bit_w) begin
        v = v - (r + bit_w);
        r = (r >> 1) + bit_w;
      end else begin
        r = r >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return r;
  endfunction

  // Restoring shift-subtract quotient, used only at elaboration.
  function automatic logic [63:0] quot64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    integer k;
    rem = '0;
    q = '0;
    if (den != 64'd0) begin
      for (k = 63; k >= 0; k--) begin
        rem = {rem[63:0], num[k]};
        if (rem >= {1'b0, den}) begin
          rem = rem - {1'b0, den};
          q[k] = 1'b1;
        end
      end
    end
    return q;
  endfunction

  // One table sample: sqrt plus the mean gap between sqrt and its chord,
  // rounded half up from Q30 to efb fraction bits.
  function automatic logic [63:0] rom_entry(input int i, input int efb);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ya;
    logic [63:0] yb;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] t;
    logic [63:0] q30;
    logic [63:0] half;
    int rs;
    rs = 30 - efb;
    if (i == 0) begin
      return 64'h1 << efb;
    end
    if (i == TABLE_ENTRIES - 1) begin
      return 64'h2 << efb;
    end
    a    = 64'd64 + 64'(i);
    b    = a + 64'd1;
    ya   = isqrt64(a << 54);
    yb   = isqrt64(b << 54);
    num  = (64'd3 * a * a + 64'd3 * a + 64'd1) << 44;
    den  = (64'd96 * (b * yb + a * ya)) >> 16;
    t    = quot64(num, den);
    q30  = t - ((yb - ya) >> 1);
    half = (64'h1 << rs) >> 1;
    return (q30 + half) >> rs;
  endfunction

endpackage

// ----- hw/rtl/fsti_decode.sv -----
// First pipeline stage: splits the float word into exponent, table index and weight.
// Depends on fsti_pkg.
`timescale 1ns / 1ps

module fsti_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  input  logic [fsti_pkg::WORD_W-1:0]  up_word,
  output logic                         up_ready,
  output logic                         dn_valid,
  output fsti_pkg::dec_t               dn_data,
  input  logic                         dn_ready
);
  import fsti_pkg::*;

  logic                valid_r;
  dec_t                dec_r;
  dec_t                dec_nxt;
  logic [EXP_W-1:0]    bexp;
  logic [FRAC_W+1:0]   m;

  assign up_ready = !valid_r || dn_ready;

  always_comb begin
    bexp = up_word[WORD_W-2 -: EXP_W];
    m = {2'b01, up_word[FRAC_W-1:0]};
    // An even biased exponent is an odd unbiased one: double the mantissa.
    if (!bexp[0]) begin
      m = m << 1;
    end
    m = m - {2'b01, {FRAC_W{1'b0}}};
    dec_nxt.word = up_word;
    dec_nxt.pass = (bexp == EXP_SPECIAL);
    dec_nxt.nexp = EXP_W'(({1'b0, bexp} + 9'd1) >> 1) + EXP_REBIAS;
    dec_nxt.idx  = m[FRAC_W+1 -: IDX_W];
    dec_nxt.f    = m[LOW_BITS-1:0];
    dec_nxt.ovf  = (m[FRAC_W+1 -: IDX_W] >= IDX_W'(TABLE_ENTRIES - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      dec_r <= dec_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = dec_r;

endmodule

// ----- hw/rtl/fsti_table.sv -----
// Second pipeline stage: reads the two neighboring samples from the constant table.
// Depends on fsti_pkg.
`timescale 1ns / 1ps

module fsti_table #(
  parameter int ENTRY_FRAC_BITS = fsti_pkg::ENTRY_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  input  fsti_pkg::dec_t             up_data,
  output logic                       up_ready,
  output logic                       dn_valid,
  output fsti_pkg::dec_t             dn_data,
  output logic [ENTRY_FRAC_BITS+1:0] dn_lo,
  output logic [ENTRY_FRAC_BITS+1:0] dn_hi,
  input  logic                       dn_ready
);
  import fsti_pkg::*;

  localparam int EW = ENTRY_FRAC_BITS + 2;

  logic [EW-1:0]    rom_w [TABLE_ENTRIES];
  logic [IDX_W-1:0] lo_idx;
  logic [IDX_W-1:0] hi_idx;
  logic             valid_r;
  dec_t             meta_r;
  logic [EW-1:0]    lo_r;
  logic [EW-1:0]    hi_r;

  // Samples are worked out at elaboration; the table is pure constant logic.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
    localparam logic [63:0] SAMPLE = rom_entry(g, ENTRY_FRAC_BITS);
    assign rom_w[g] = SAMPLE[EW-1:0];
  end

  // An out-of-range index saturates later, so any in-range read will do.
  assign lo_idx   = up_data.ovf ? '0 : up_data.idx;
  assign hi_idx   = up_data.ovf ? '0 : up_data.idx + IDX_W'(1);
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready && up_valid) begin
      meta_r <= up_data;
      lo_r   <= rom_w[lo_idx];
      hi_r   <= rom_w[hi_idx];
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = meta_r;
  assign dn_lo    = lo_r;
  assign dn_hi    = hi_r;

endmodule

// ----- hw/rtl/fsti_interp.sv -----
// Third and fourth pipeline stages: weighted products, then sum, saturation and packing.
// Depends on fsti_pkg.
`timescale 1ns / 1ps

module fsti_interp #(
  parameter int ENTRY_FRAC_BITS = fsti_pkg::ENTRY_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  input  fsti_pkg::dec_t              up_data,
  input  logic [ENTRY_FRAC_BITS+1:0]  up_lo,
  input  logic [ENTRY_FRAC_BITS+1:0]  up_hi,
  output logic                        up_ready,
  output logic                        dn_valid,
  output logic [fsti_pkg::WORD_W-1:0] dn_root,
  output logic                        dn_pass,
  input  logic                        dn_ready
);
  import fsti_pkg::*;

  localparam int EW = ENTRY_FRAC_BITS + 2;
  localparam int PW = EW + LOW_BITS + 1;
  localparam int SW = PW + 1;
  localparam int VW = SW - LOW_BITS;
  localparam logic [VW-1:0] V_LIMIT = VW'(2) << ENTRY_FRAC_BITS;

  logic                       rdy_a;
  logic                       rdy_b;
  logic [LOW_BITS:0]          w_lo;
  logic [PW-1:0]              prod_lo_nxt;
  logic [PW-1:0]              prod_hi_nxt;
  logic                       valid_a_r;
  dec_t                       meta_a_r;
  logic [PW-1:0]              prod_lo_r;
  logic [PW-1:0]              prod_hi_r;
  logic [SW-1:0]              sum;
  logic [VW-1:0]              v;
  logic [ENTRY_FRAC_BITS-1:0] v_frac;
  logic [FRAC_W-1:0]          frac_scaled;
  logic [FRAC_W-1:0]          frac_nxt;
  logic [WORD_W-1:0]          root_nxt;
  logic                       valid_b_r;
  logic [WORD_W-1:0]          root_r;
  logic                       pass_r;

  assign rdy_b    = !valid_b_r || dn_ready;
  assign rdy_a    = !valid_a_r || rdy_b;
  assign up_ready = rdy_a;

  // Stage A: one product per neighbor, weights summing to 2^17.
  assign w_lo        = (LOW_BITS+1)'(1) << LOW_BITS;
  assign prod_lo_nxt = PW'(up_lo) * PW'(w_lo - {1'b0, up_data.f});
  assign prod_hi_nxt = PW'(up_hi) * PW'(up_data.f);

  // Stage B: truncated blend, then fraction bits scaled to 23.
  assign sum    = SW'(prod_lo_r) + SW'(prod_hi_r);
  assign v      = sum[SW-1:LOW_BITS];
  assign v_frac = v[ENTRY_FRAC_BITS-1:0];

  if (ENTRY_FRAC_BITS >= FRAC_W) begin : g_narrow
    assign frac_scaled = v_frac[ENTRY_FRAC_BITS-1 -: FRAC_W];
  end else begin : g_widen
    assign frac_scaled = {v_frac, {(FRAC_W-ENTRY_FRAC_BITS){1'b0}}};
  end

  always_comb begin
    if (meta_a_r.ovf || (v >= V_LIMIT)) begin
      frac_nxt = '1;
    end else begin
      frac_nxt = frac_scaled;
    end
    if (meta_a_r.pass) begin
      root_nxt = meta_a_r.word;
    end else begin
      root_nxt = {meta_a_r.word[WORD_W-1], meta_a_r.nexp, frac_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (rdy_a) begin
        valid_a_r <= up_valid;
      end
      if (rdy_b) begin
        valid_b_r <= valid_a_r;
      end
    end
    if (rdy_a && up_valid) begin
      meta_a_r  <= up_data;
      prod_lo_r <= prod_lo_nxt;
      prod_hi_r <= prod_hi_nxt;
    end
    if (rdy_b && valid_a_r) begin
      root_r <= root_nxt;
      pass_r <= meta_a_r.pass;
    end
  end

  assign dn_valid = valid_b_r;
  assign dn_root  = root_r;
  assign dn_pass  = pass_r;

endmodule

// ----- hw/rtl/float_sqrt_table_interp_unit.sv -----
// Top level of the single-precision approximate square root unit.
// Depends on fsti_pkg, fsti_decode, fsti_table, fsti_interp and the defines header.
`timescale 1ns / 1ps
`include "float_sqrt_table_interp_unit_defines.svh"

// The unit takes one single-precision word per cycle while in_stall is low
// and returns one approximate square root word per input word, in order,
// through the decode, table, multiply and sum registers. The four register
// stages are decode, table read, the two interpolation multiplies, and the
// final sum with saturation; the multiply stage sets the clock, and every
// stage holds its own valid bit so a word can enter on every cycle that the input is not stalled. A stall
// on the output backs up only as far as the first empty stage, so the input
// keeps accepting words until all four stages hold one. The result exponent
// is the halved unbiased exponent rebiased; the mantissa (doubled for an odd
// exponent) indexes a 193-entry constant table of corrected samples over
// [1,4], and the low 17 bits blend the two neighboring samples with truncation.
// NaN and infinity pass through unchanged with out_passed_through set; zero and
// subnormals are not special-cased, and the sign bit is always copied. The
// table needs no load or clearing pass: it is constant logic built at
// elaboration from ENTRY_FRAC_BITS (16 to 30), the sample precision.
module float_sqrt_table_interp_unit #(
  parameter int ENTRY_FRAC_BITS = fsti_pkg::ENTRY_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [fsti_pkg::WORD_W-1:0] in_operand_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fsti_pkg::WORD_W-1:0] out_root_bits,
  output logic                        out_passed_through
);
  import fsti_pkg::*;

  localparam int EW = ENTRY_FRAC_BITS + 2;

  // Decode to table read.
  logic          dec_valid;
  dec_t          dec_data;
  logic          dec_ready;
  // Table read to interpolation.
  logic          tab_valid;
  dec_t          tab_data;
  logic [EW-1:0] tab_lo;
  logic [EW-1:0] tab_hi;
  logic          tab_ready;
  logic          interp_ready;
  logic          in_ready;

  fsti_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_word  (in_operand_bits),
    .up_ready (in_ready),
    .dn_valid (dec_valid),
    .dn_data  (dec_data),
    .dn_ready (tab_ready)
  );

  fsti_table #(
    .ENTRY_FRAC_BITS (ENTRY_FRAC_BITS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_data  (dec_data),
    .up_ready (tab_ready),
    .dn_valid (tab_valid),
    .dn_data  (tab_data),
    .dn_lo    (tab_lo),
    .dn_hi    (tab_hi),
    .dn_ready (interp_ready)
  );

  fsti_interp #(
    .ENTRY_FRAC_BITS (ENTRY_FRAC_BITS)
  ) u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (tab_valid),
    .up_data  (tab_data),
    .up_lo    (tab_lo),
    .up_hi    (tab_hi),
    .up_ready (interp_ready),
    .dn_valid (out_valid),
    .dn_root  (out_root_bits),
    .dn_pass  (out_passed_through),
    .dn_ready (!out_stall)
  );

  assign in_stall = !in_ready;

  // The pipeline leaves reset empty.
  `FSTI_ASSERT_RESET(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")
  // The input only stalls once every stage is full and the output is held.
  `FSTI_ASSERT(a_stall_only_full, in_stall |-> (out_valid && out_stall), "bubble not filled")
  // A passed-through word keeps its all-ones exponent.
  `FSTI_ASSERT(a_pass_exp, (out_valid && out_passed_through) |-> (out_root_bits[30:23] == EXP_SPECIAL), "passthrough exponent lost")
  // A computed root can never carry the special exponent.
  `FSTI_ASSERT(a_root_exp, (out_valid && !out_passed_through) |-> (out_root_bits[30:23] != EXP_SPECIAL), "computed root has special exponent")

endmodule
